/* hw/rtl/tgr_pkg.sv */
package tgr_pkg;

  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int PIX_W   = 8;
  localparam int COLOR_W = 16;

  localparam logic               REQ_WRITE   = 1'b0;
  localparam logic               REQ_PIXEL   = 1'b1;
  localparam logic [COLOR_W-1:0] LIT_COLOR   = 16'hFFFF;
  localparam logic [COLOR_W-1:0] DARK_COLOR  = 16'h0000;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h00;

  localparam int CELL_H_LOG2 = 3;
  localparam int DIV6_MUL    = 171;
  localparam int DIV6_SHIFT  = 10;
  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam logic [2:0] SPACE_ROW  = 3'd7;

  typedef logic [6:0] glyph_col_t;

  typedef struct packed {
    logic       lit_ok;
    logic [2:0] glyph_bit;
    logic [2:0] glyph_col;
  } pix_tag_t;

  localparam glyph_col_t FONT_ALNUM [36][5] = '{
    '{7'h3e,7'h51,7'h49,7'h45,7'h3e}, '{7'h00,7'h42,7'h7f,7'h40,7'h00},
    '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4b,7'h31},
    '{7'h18,7'h14,7'h12,7'h7f,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
    '{7'h3c,7'h4a,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
    '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1e},
    '{7'h7e,7'h11,7'h11,7'h11,7'h7e}, '{7'h7f,7'h49,7'h49,7'h49,7'h36},
    '{7'h3e,7'h41,7'h41,7'h41,7'h22}, '{7'h7f,7'h41,7'h41,7'h22,7'h1c},
    '{7'h7f,7'h49,7'h49,7'h49,7'h41}, '{7'h7f,7'h09,7'h09,7'h09,7'h01},
    '{7'h3e,7'h41,7'h49,7'h49,7'h7a}, '{7'h7f,7'h08,7'h08,7'h08,7'h7f},
    '{7'h00,7'h41,7'h7f,7'h41,7'h00}, '{7'h20,7'h40,7'h41,7'h3f,7'h01},
    '{7'h7f,7'h08,7'h14,7'h22,7'h41}, '{7'h7f,7'h40,7'h40,7'h40,7'h40},
    '{7'h7f,7'h02,7'h0c,7'h02,7'h7f}, '{7'h7f,7'h04,7'h08,7'h10,7'h7f},
    '{7'h3e,7'h41,7'h41,7'h41,7'h3e}, '{7'h7f,7'h09,7'h09,7'h09,7'h06},
    '{7'h3e,7'h41,7'h51,7'h21,7'h5e}, '{7'h7f,7'h09,7'h19,7'h29,7'h46},
    '{7'h46,7'h49,7'h49,7'h49,7'h31}, '{7'h01,7'h01,7'h7f,7'h01,7'h01},
    '{7'h3f,7'h40,7'h40,7'h40,7'h3f}, '{7'h1f,7'h20,7'h40,7'h20,7'h1f},
    '{7'h3f,7'h40,7'h38,7'h40,7'h3f}, '{7'h63,7'h14,7'h08,7'h14,7'h63},
    '{7'h07,7'h08,7'h70,7'h08,7'h07}, '{7'h61,7'h51,7'h49,7'h45,7'h43}
  };

  localparam glyph_col_t GLYPH_BLANK    [5] = '{7'h00,7'h00,7'h00,7'h00,7'h00};
  localparam glyph_col_t GLYPH_COLON    [5] = '{7'h00,7'h36,7'h36,7'h00,7'h00};
  localparam glyph_col_t GLYPH_SEMI     [5] = '{7'h00,7'h56,7'h36,7'h00,7'h00};
  localparam glyph_col_t GLYPH_PERIOD   [5] = '{7'h00,7'h60,7'h60,7'h00,7'h00};
  localparam glyph_col_t GLYPH_MINUS    [5] = '{7'h08,7'h08,7'h08,7'h08,7'h08};
  localparam glyph_col_t GLYPH_SLASH    [5] = '{7'h20,7'h10,7'h08,7'h04,7'h02};
  localparam glyph_col_t GLYPH_EQUALS   [5] = '{7'h14,7'h14,7'h14,7'h14,7'h14};
  localparam glyph_col_t GLYPH_STAR     [5] = '{7'h14,7'h08,7'h3e,7'h08,7'h14};
  localparam glyph_col_t GLYPH_QUESTION [5] = '{7'h02,7'h01,7'h51,7'h09,7'h06};

  function automatic glyph_col_t glyph_column(logic [CHAR_W-1:0] ch, logic [2:0] col);
    logic [CHAR_W-1:0] c;
    logic [5:0]        idx;
    glyph_col_t        g [5];
    c   = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
    idx = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      idx = 6'(c - 8'h30);
      g   = FONT_ALNUM[idx];
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      idx = 6'(c - 8'h41 + 8'd10);
      g   = FONT_ALNUM[idx];
    end else begin
      unique case (c)
        BLANK_CHAR, 8'h20: g = GLYPH_BLANK;
        8'h3a:             g = GLYPH_COLON;
        8'h3b:             g = GLYPH_SEMI;
        8'h2e:             g = GLYPH_PERIOD;
        8'h2d:             g = GLYPH_MINUS;
        8'h2f:             g = GLYPH_SLASH;
        8'h3d:             g = GLYPH_EQUALS;
        8'h2a:             g = GLYPH_STAR;
        default:           g = GLYPH_QUESTION;
      endcase
    end
    return (col < GLYPH_COLS) ? g[col] : 7'h00;
  endfunction

endpackage

/* hw/rtl/tgr_if.sv */
interface tgr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [tgr_pkg::ROW_W-1:0]  text_row;
  logic [tgr_pkg::COL_W-1:0]  text_column;
  logic [tgr_pkg::CHAR_W-1:0] char_code;
  logic [tgr_pkg::PIX_W-1:0]  pixel_x;
  logic [tgr_pkg::PIX_W-1:0]  pixel_y;

  modport source (output valid, req_type, text_row, text_column, char_code, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, req_type, text_row, text_column, char_code, pixel_x, pixel_y,
                output ready);
endinterface

interface tgr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgr_pkg::COLOR_W-1:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

/* hw/rtl/text_mode_glyph_rasterizer_unit.sv */
// Text-mode character generator, 5x7 font in 6x8 cells.
// in_ch (valid/ready) takes two kinds of request: req_type 0 stores char_code
// at (text_row, text_column) and gives no result; req_type 1 asks for the
// color of screen pixel (pixel_x, pixel_y) and gives one result on out_ch.
// Rate: one request per cycle while in_ch.ready is high, reads and writes alike, set by the single
// port of the text memory (one access a cycle).
// Pixel path: the memory read is registered, then the font lookup goes into
// the output register.
// A write is visible to every pixel request accepted after it.
// Reset: the text memory is swept to blank, one entry a cycle, over all
// TEXT_ROWS*TEXT_COLUMNS entries (640 by default) while in_ch.ready is low.
// Stall: with out_ch.ready low the output holds; one more pixel request is
// taken into the lookup stage, then in_ch.ready drops until the output drains.
module text_mode_glyph_rasterizer_unit #(
  parameter int TEXT_ROWS     = 16,
  parameter int TEXT_COLUMNS  = 40,
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 135
) (
  input  logic       clk,
  input  logic       rst_n,
  tgr_in_if.sink     in_ch,
  tgr_out_if.source  out_ch
);
  import tgr_pkg::*;

  localparam int DEPTH = TEXT_ROWS * TEXT_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic              clearing_r, clearing_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              accept;
  logic              is_pixel;
  logic              wr_ok;
  logic [AW-1:0]     dec_addr;
  pix_tag_t          dec_tag;
  logic              space;
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  tgr_decode #(
    .TEXT_ROWS    (TEXT_ROWS),
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_decode (
    .req_type   (in_ch.req_type),
    .text_row   (in_ch.text_row),
    .text_column(in_ch.text_column),
    .pixel_x    (in_ch.pixel_x),
    .pixel_y    (in_ch.pixel_y),
    .wr_ok      (wr_ok),
    .addr       (dec_addr),
    .tag        (dec_tag)
  );

  always_comb begin
    accept       = in_ch.valid && in_ch.ready;
    is_pixel     = (in_ch.req_type == REQ_PIXEL);
    ram_en       = clearing_r || (accept && (is_pixel || wr_ok));
    ram_we       = clearing_r || (accept && !is_pixel && wr_ok);
    ram_addr     = clearing_r ? clr_addr_r : dec_addr;
    ram_wdata    = clearing_r ? BLANK_CHAR : in_ch.char_code;
    clearing_nxt = clearing_r && (clr_addr_r != LAST_ADDR);
    clr_addr_nxt = clearing_r ? clr_addr_r + AW'(1) : clr_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  tgr_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_text_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  tgr_shade u_shade (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept && is_pixel),
    .tag   (dec_tag),
    .rdata (ram_rdata),
    .space (space),
    .out_ch(out_ch)
  );

  assign in_ch.ready = !clearing_r && space;

endmodule

/* hw/rtl/tgr_ram.sv */
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 640,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tgr_decode.sv */
module tgr_decode #(
  parameter int TEXT_ROWS     = 16,
  parameter int TEXT_COLUMNS  = 40,
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 135,
  localparam int DEPTH = TEXT_ROWS * TEXT_COLUMNS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       req_type,
  input  logic [tgr_pkg::ROW_W-1:0]  text_row,
  input  logic [tgr_pkg::COL_W-1:0]  text_column,
  input  logic [tgr_pkg::PIX_W-1:0]  pixel_x,
  input  logic [tgr_pkg::PIX_W-1:0]  pixel_y,
  output logic                       wr_ok,
  output logic [AW-1:0]              addr,
  output tgr_pkg::pix_tag_t          tag
);
  import tgr_pkg::*;

  logic [15:0] x_prod;
  logic [5:0]  cell_idx;
  logic [7:0]  cell_x6;
  logic [2:0]  gcol;
  logic [4:0]  prow;
  logic [2:0]  gbit;
  logic [6:0]  row_sel;
  logic [6:0]  col_sel;
  logic [31:0] addr_full;

  always_comb begin
    x_prod   = 16'(pixel_x) * 16'(DIV6_MUL);
    cell_idx = 6'(x_prod >> DIV6_SHIFT);
    cell_x6  = 8'({2'b00, cell_idx} * 8'd6);
    gcol     = 3'(pixel_x - cell_x6);
    prow     = pixel_y[PIX_W-1:CELL_H_LOG2];
    gbit     = pixel_y[CELL_H_LOG2-1:0];

    wr_ok = (32'(text_row) < 32'(TEXT_ROWS)) && (32'(text_column) < 32'(TEXT_COLUMNS));

    tag.glyph_bit = gbit;
    tag.glyph_col = gcol;
    tag.lit_ok    = (32'(pixel_x) < 32'(SCREEN_WIDTH)) && (32'(pixel_y) < 32'(SCREEN_HEIGHT))
                 && (32'(prow) < 32'(TEXT_ROWS)) && (32'(cell_idx) < 32'(TEXT_COLUMNS))
                 && (gbit != SPACE_ROW) && (gcol < GLYPH_COLS);

    row_sel   = (req_type == REQ_PIXEL) ? 7'(prow) : 7'(text_row);
    col_sel   = (req_type == REQ_PIXEL) ? 7'(cell_idx) : 7'(text_column);
    addr_full = 32'(row_sel) * 32'(TEXT_COLUMNS) + 32'(col_sel);
    addr      = addr_full[AW-1:0];
  end

endmodule

/* hw/rtl/tgr_shade.sv */
module tgr_shade (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  tgr_pkg::pix_tag_t         tag,
  input  logic [tgr_pkg::CHAR_W-1:0] rdata,
  output logic                      space,
  tgr_out_if.source                 out_ch
);
  import tgr_pkg::*;

  logic        s1_vld_r, s1_vld_nxt;
  pix_tag_t    s1_tag_r;
  logic        out_vld_r, out_vld_nxt;
  logic [COLOR_W-1:0] color_r;
  logic        adv;
  glyph_col_t  gcol_bits;

  always_comb begin
    adv         = s1_vld_r && (!out_vld_r || out_ch.ready);
    space       = !s1_vld_r || adv;
    s1_vld_nxt  = load || (s1_vld_r && !adv);
    out_vld_nxt = adv || (out_vld_r && !out_ch.ready);
    gcol_bits   = glyph_column(rdata, s1_tag_r.glyph_col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_tag_r <= tag;
    end
    if (adv) begin
      color_r <= (s1_tag_r.lit_ok && gcol_bits[s1_tag_r.glyph_bit]) ? LIT_COLOR : DARK_COLOR;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.pixel_color = color_r;

endmodule

/* hw/rtl/tgr_check.sv */
module tgr_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_color
);
  import tgr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color))
    else $error("result changed while stalled");

  a_color_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pixel_color == LIT_COLOR) || (pixel_color == DARK_COLOR))
    else $error("result is neither lit nor dark");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("request taken during memory clear");

  a_pixel_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (req_type == REQ_PIXEL) && !out_valid |=> ##1 out_valid)
    else $error("pixel result missing two cycles after request");

endmodule

bind text_mode_glyph_rasterizer_unit tgr_check u_tgr_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .req_type   (in_ch.req_type),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_color(out_ch.pixel_color)
);
